/* design/csp_pkg.sv */
// Shared types and constants for the connection slot pool policy unit.
`timescale 1ns / 1ps
`default_nettype none

package csp_pkg;

  localparam int POOL_SLOTS = 8;
  localparam int IDX_W      = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int CNT_W      = $clog2(POOL_SLOTS + 2);

  localparam int CMD_W    = 2;
  localparam int HOST_W   = 32;
  localparam int PORT_W   = 16;
  localparam int TIME_W   = 32;
  localparam int HANDLE_W = 4;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int EVICT_W  = 4;
  localparam int TMO_W    = 16;

  localparam logic [SLOT_W-1:0] NO_SLOT       = 4'd8;
  localparam logic [TMO_W-1:0]  TIMEOUT_RESET = 16'd60;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_EVICT   = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_REUSED        = 3'd0,
    ST_NEW_POOLED    = 3'd1,
    ST_NEW_BYPASS    = 3'd2,
    ST_CONNECT_FAIL  = 3'd3,
    ST_SLOT_UPDATED  = 3'd4,
    ST_BYPASS_CLOSED = 3'd5
  } status_t;

  typedef struct packed {
    logic [HOST_W-1:0] host;
    logic [PORT_W-1:0] port;
    logic              secure;
  } key_t;

endpackage

`default_nettype wire

/* design/csp_if.sv */
// Valid/ready channel interfaces for the request and result words of the pool unit.
`timescale 1ns / 1ps
`default_nettype none

interface csp_in_if;
  logic                           valid;
  logic                           ready;
  logic [csp_pkg::CMD_W-1:0]      command;
  logic [csp_pkg::HOST_W-1:0]     host_key;
  logic [csp_pkg::PORT_W-1:0]     port;
  logic                           is_tls;
  logic                           alive;
  logic                           connect_ok;
  logic [csp_pkg::TIME_W-1:0]     now_time;
  logic [csp_pkg::HANDLE_W-1:0]   handle;

  modport source (output valid, command, host_key, port, is_tls, alive, connect_ok,
                  now_time, handle, input ready);
  modport sink (input valid, command, host_key, port, is_tls, alive, connect_ok,
                now_time, handle, output ready);
endinterface

interface csp_out_if;
  logic                         valid;
  logic                         ready;
  csp_pkg::status_t             status;
  logic [csp_pkg::SLOT_W-1:0]   slot;
  logic [csp_pkg::EVICT_W-1:0]  evicted_count;

  modport source (output valid, status, slot, evicted_count, input ready);
  modport sink (input valid, status, slot, evicted_count, output ready);
endinterface

`default_nettype wire

/* design/connection_slot_pool_policy_unit.sv */
// Top level of the connection slot pool policy unit with its slot memories and sequencer.
// Release and evict: dispatch, then done, which loads the result word into the output
// register once it is free or taken. Acquire: dispatch, then the match scan, which ends in
// done when a slot is reused; else the free state, an oldest scan when the pool is full,
// commit and done. The next request can be accepted in the cycle after a result enters the
// output register. Scans read one slot at a time through the single memory read port.
// Synchronous active-low reset empties the pool and loads the idle timeout with 60.
`timescale 1ns / 1ps
`default_nettype none

module connection_slot_pool_policy_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  csp_in_if.sink                          in_ch,
  csp_out_if.source                       out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [csp_pkg::TMO_W-1:0]  cfg_wdata
);
  import csp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_MREAD,
    S_MEVAL,
    S_FREE,
    S_OREAD,
    S_OEVAL,
    S_COMMIT,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic [TMO_W-1:0]      timeout_r;
  logic [POOL_SLOTS-1:0] valid_r, valid_nxt;
  logic [POOL_SLOTS-1:0] busy_r, busy_nxt;

  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [HOST_W-1:0]   host_r, host_nxt;
  logic [PORT_W-1:0]   port_r, port_nxt;
  logic                tls_r, tls_nxt;
  logic                alive_r, alive_nxt;
  logic                ok_r, ok_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [HANDLE_W-1:0] handle_r, handle_nxt;

  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  slot_sel_r, slot_sel_nxt;
  logic              have_slot_r, have_slot_nxt;
  logic              from_oldest_r, from_oldest_nxt;
  logic [TIME_W-1:0] oldest_time_r, oldest_time_nxt;
  logic [CNT_W-1:0]  evict_cnt_r, evict_cnt_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [EVICT_W-1:0] out_evict_r, out_evict_nxt;

  key_t              key_mem_r [POOL_SLOTS];
  logic [TIME_W-1:0] stamp_mem_r [POOL_SLOTS];
  key_t              key_rd_r;
  logic [TIME_W-1:0] stamp_rd_r;
  logic              key_we;
  logic              stamp_we;
  logic [IDX_W-1:0]  wr_addr;
  logic [TIME_W-1:0] stamp_wdata;
  key_t              key_wdata;

  logic             in_accept;
  logic             idx_last;
  logic [IDX_W-1:0] h_idx;
  logic             h_hit;
  logic             key_match;
  logic             expired;
  logic             any_free;
  logic [IDX_W-1:0] first_free;

  assign in_ch.ready         = (state_r == S_IDLE);
  assign in_accept           = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.slot         = out_slot_r;
  assign out_ch.evicted_count = out_evict_r;

  assign idx_last  = (idx_r == IDX_W'(POOL_SLOTS - 1));
  assign h_idx     = IDX_W'(handle_r);
  assign h_hit     = (32'(handle_r) < POOL_SLOTS) && valid_r[h_idx];
  assign key_match = valid_r[idx_r] && !busy_r[idx_r] && (key_rd_r.host == host_r) &&
                     (key_rd_r.port == port_r) && (key_rd_r.secure == tls_r);
  assign expired   = (now_r >= stamp_rd_r) &&
                     ((now_r - stamp_rd_r) > {{(TIME_W-TMO_W){1'b0}}, timeout_r});
  assign any_free  = ~&valid_r;
  assign key_wdata = '{host: host_r, port: port_r, secure: tls_r};

  always_comb begin
    first_free = '0;
    for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        first_free = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem_r[wr_addr] <= key_wdata;
    end
    if (stamp_we) begin
      stamp_mem_r[wr_addr] <= stamp_wdata;
    end
    key_rd_r   <= key_mem_r[idx_r];
    stamp_rd_r <= stamp_mem_r[idx_r];
  end

  always_comb begin
    state_nxt       = state_r;
    valid_nxt       = valid_r;
    busy_nxt        = busy_r;
    cmd_nxt         = cmd_r;
    host_nxt        = host_r;
    port_nxt        = port_r;
    tls_nxt         = tls_r;
    alive_nxt       = alive_r;
    ok_nxt          = ok_r;
    now_nxt         = now_r;
    handle_nxt      = handle_r;
    idx_nxt         = idx_r;
    slot_sel_nxt    = slot_sel_r;
    have_slot_nxt   = have_slot_r;
    from_oldest_nxt = from_oldest_r;
    oldest_time_nxt = oldest_time_r;
    evict_cnt_nxt   = evict_cnt_r;
    res_status_nxt  = res_status_r;
    res_slot_nxt    = res_slot_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_slot_nxt    = out_slot_r;
    out_evict_nxt   = out_evict_r;
    key_we          = 1'b0;
    stamp_we        = 1'b0;
    wr_addr         = slot_sel_r;
    stamp_wdata     = now_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          cmd_nxt    = in_ch.command;
          host_nxt   = in_ch.host_key;
          port_nxt   = in_ch.port;
          tls_nxt    = in_ch.is_tls;
          alive_nxt  = in_ch.alive;
          ok_nxt     = in_ch.connect_ok;
          now_nxt    = in_ch.now_time;
          handle_nxt = in_ch.handle;
          state_nxt  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        evict_cnt_nxt   = '0;
        idx_nxt         = '0;
        have_slot_nxt   = 1'b0;
        from_oldest_nxt = 1'b0;
        oldest_time_nxt = now_r;
        res_status_nxt  = ST_BYPASS_CLOSED;
        res_slot_nxt    = NO_SLOT;
        state_nxt       = S_DONE;
        case (cmd_r)
          CMD_ACQUIRE: begin
            state_nxt = S_MREAD;
          end
          CMD_RELEASE: begin
            if (h_hit) begin
              busy_nxt[h_idx] = 1'b0;
              stamp_we        = 1'b1;
              wr_addr         = h_idx;
              res_status_nxt  = ST_SLOT_UPDATED;
              res_slot_nxt    = handle_r;
            end
          end
          CMD_EVICT: begin
            if (h_hit) begin
              valid_nxt[h_idx] = 1'b0;
              busy_nxt[h_idx]  = 1'b0;
              evict_cnt_nxt    = CNT_W'(1);
              res_status_nxt   = ST_SLOT_UPDATED;
              res_slot_nxt     = handle_r;
            end
          end
          default: begin
            res_status_nxt = ST_BYPASS_CLOSED;
          end
        endcase
      end
      S_MREAD: begin
        state_nxt = S_MEVAL;
      end
      S_MEVAL: begin
        if (key_match && !expired && alive_r) begin
          busy_nxt[idx_r] = 1'b1;
          res_status_nxt  = ST_REUSED;
          res_slot_nxt    = SLOT_W'(idx_r);
          state_nxt       = S_DONE;
        end else begin
          if (key_match) begin
            valid_nxt[idx_r] = 1'b0;
            busy_nxt[idx_r]  = 1'b0;
            evict_cnt_nxt    = evict_cnt_r + CNT_W'(1);
          end
          if (idx_last) begin
            state_nxt = S_FREE;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = S_MREAD;
          end
        end
      end
      S_FREE: begin
        if (any_free) begin
          slot_sel_nxt  = first_free;
          have_slot_nxt = 1'b1;
          state_nxt     = S_COMMIT;
        end else begin
          idx_nxt   = '0;
          state_nxt = S_OREAD;
        end
      end
      S_OREAD: begin
        state_nxt = S_OEVAL;
      end
      S_OEVAL: begin
        if (!busy_r[idx_r] && (stamp_rd_r < oldest_time_r)) begin
          oldest_time_nxt = stamp_rd_r;
          slot_sel_nxt    = idx_r;
          have_slot_nxt   = 1'b1;
          from_oldest_nxt = 1'b1;
        end
        if (idx_last) begin
          state_nxt = S_COMMIT;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_OREAD;
        end
      end
      S_COMMIT: begin
        if (from_oldest_r) begin
          valid_nxt[slot_sel_r] = 1'b0;
          busy_nxt[slot_sel_r]  = 1'b0;
          evict_cnt_nxt         = evict_cnt_r + CNT_W'(1);
        end
        if (!ok_r) begin
          res_status_nxt = ST_CONNECT_FAIL;
          res_slot_nxt   = NO_SLOT;
        end else if (have_slot_r) begin
          key_we                = 1'b1;
          stamp_we              = 1'b1;
          valid_nxt[slot_sel_r] = 1'b1;
          busy_nxt[slot_sel_r]  = 1'b1;
          res_status_nxt        = ST_NEW_POOLED;
          res_slot_nxt          = SLOT_W'(slot_sel_r);
        end else begin
          res_status_nxt = ST_NEW_BYPASS;
          res_slot_nxt   = NO_SLOT;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_evict_nxt  = EVICT_W'(evict_cnt_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      timeout_r   <= TIMEOUT_RESET;
      valid_r     <= '0;
      busy_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
    end
    cmd_r         <= cmd_nxt;
    host_r        <= host_nxt;
    port_r        <= port_nxt;
    tls_r         <= tls_nxt;
    alive_r       <= alive_nxt;
    ok_r          <= ok_nxt;
    now_r         <= now_nxt;
    handle_r      <= handle_nxt;
    idx_r         <= idx_nxt;
    slot_sel_r    <= slot_sel_nxt;
    have_slot_r   <= have_slot_nxt;
    from_oldest_r <= from_oldest_nxt;
    oldest_time_r <= oldest_time_nxt;
    evict_cnt_r   <= evict_cnt_nxt;
    res_status_r  <= res_status_nxt;
    res_slot_r    <= res_slot_nxt;
    out_status_r  <= out_status_nxt;
    out_slot_r    <= out_slot_nxt;
    out_evict_r   <= out_evict_nxt;
  end

`ifndef SYNTH
  a_busy_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r & ~valid_r) == '0)
    else $error("A slot is marked busy while it is not valid.");

  a_done_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && (!out_valid_r || out_ch.ready) |=> out_valid_r && (state_r == S_IDLE))
    else $error("A finished result did not enter the output register.");

  a_evict_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (32'(evict_cnt_r) <= POOL_SLOTS))
    else $error("The eviction count exceeds the number of slots.");

  a_pooled_slot_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT) && ok_r && have_slot_r |=>
      valid_r[$past(slot_sel_r)] && busy_r[$past(slot_sel_r)])
    else $error("A newly pooled slot is not marked valid and busy.");
`endif

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking testbench for the connection slot pool policy unit.
`timescale 1ns / 1ps

module tb_top;
  import csp_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int LONG_HOLD       = 300;
  localparam int CYCLE_LIMIT     = 1000000;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [HOST_W-1:0]   host;
    logic [PORT_W-1:0]   port;
    logic                tls;
    logic                alive;
    logic                ok;
    logic [TIME_W-1:0]   now;
    logic [HANDLE_W-1:0] handle;
  } request_t;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [EVICT_W-1:0] evicted;
  } outcome_t;

  typedef struct {
    request_t req;
    bit       pinned;
    outcome_t want;
  } script_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [TMO_W-1:0] cfg_wdata;

  csp_in_if  req_bus ();
  csp_out_if rsp_bus ();

  connection_slot_pool_policy_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_bus),
    .out_ch    (rsp_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  logic              pool_valid [POOL_SLOTS];
  logic              pool_busy  [POOL_SLOTS];
  logic [HOST_W-1:0] pool_host  [POOL_SLOTS];
  logic [PORT_W-1:0] pool_port  [POOL_SLOTS];
  logic              pool_tls   [POOL_SLOTS];
  logic [TIME_W-1:0] pool_stamp [POOL_SLOTS];
  logic [TMO_W-1:0]  idle_limit;

  outcome_t    pending_outcomes [$];
  script_row_t script [$];
  logic [TIME_W-1:0] wall = '0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_asks    = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;

  initial clk = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic outcome_t pool_outcome(request_t r);
    logic [EVICT_W-1:0] gone;
    logic [TIME_W-1:0]  oldest_stamp;
    int pick;
    int oldest;
    bit stale;
    gone = '0;
    pick = -1;
    oldest = -1;
    oldest_stamp = r.now;
    if (r.command == CMD_ACQUIRE) begin
      for (int i = 0; i < POOL_SLOTS; i++) begin
        if (pool_valid[i] && !pool_busy[i] && pool_host[i] == r.host &&
            pool_port[i] == r.port && pool_tls[i] == r.tls) begin
          stale = r.now >= pool_stamp[i] && (r.now - pool_stamp[i]) > idle_limit;
          if (stale || !r.alive) begin
            pool_valid[i] = 1'b0;
            pool_busy[i] = 1'b0;
            gone++;
          end else begin
            pool_busy[i] = 1'b1;
            return '{ST_REUSED, SLOT_W'(i), gone};
          end
        end
      end
      for (int i = 0; i < POOL_SLOTS; i++) begin
        if (!pool_valid[i]) begin
          pick = i;
          break;
        end
        if (!pool_busy[i] && pool_stamp[i] < oldest_stamp) begin
          oldest_stamp = pool_stamp[i];
          oldest = i;
        end
      end
      if (pick < 0 && oldest >= 0) begin
        pool_valid[oldest] = 1'b0;
        pool_busy[oldest] = 1'b0;
        gone++;
        pick = oldest;
      end
      if (!r.ok) return '{ST_CONNECT_FAIL, NO_SLOT, gone};
      if (pick < 0) return '{ST_NEW_BYPASS, NO_SLOT, gone};
      pool_host[pick] = r.host;
      pool_port[pick] = r.port;
      pool_tls[pick] = r.tls;
      pool_valid[pick] = 1'b1;
      pool_busy[pick] = 1'b1;
      pool_stamp[pick] = r.now;
      return '{ST_NEW_POOLED, SLOT_W'(pick), gone};
    end
    if (r.command == CMD_UNUSED || r.handle >= POOL_SLOTS) return '{ST_BYPASS_CLOSED, NO_SLOT, '0};
    if (!pool_valid[r.handle]) return '{ST_BYPASS_CLOSED, NO_SLOT, '0};
    if (r.command == CMD_RELEASE) begin
      pool_busy[r.handle] = 1'b0;
      pool_stamp[r.handle] = r.now;
      return '{ST_SLOT_UPDATED, r.handle, '0};
    end
    pool_valid[r.handle] = 1'b0;
    pool_busy[r.handle] = 1'b0;
    return '{ST_SLOT_UPDATED, r.handle, EVICT_W'(1)};
  endfunction

  function automatic request_t acq_req(logic [HOST_W-1:0] host, logic [PORT_W-1:0] port,
                                       logic tls, logic alive, logic ok,
                                       logic [TIME_W-1:0] now);
    request_t r;
    r = '0;
    r.command = CMD_ACQUIRE;
    r.host = host;
    r.port = port;
    r.tls = tls;
    r.alive = alive;
    r.ok = ok;
    r.now = now;
    return r;
  endfunction

  function automatic request_t slot_req(logic [CMD_W-1:0] command,
                                        logic [HANDLE_W-1:0] handle,
                                        logic [TIME_W-1:0] now);
    request_t r;
    r = '0;
    r.command = command;
    r.handle = handle;
    r.now = now;
    return r;
  endfunction

  function automatic outcome_t outc(status_t status, logic [SLOT_W-1:0] slot,
                                    logic [EVICT_W-1:0] evicted);
    outcome_t o;
    o.status = status;
    o.slot = slot;
    o.evicted = evicted;
    return o;
  endfunction

  task automatic add_row(request_t r, bit pinned, outcome_t want);
    script_row_t row;
    row.req = r;
    row.pinned = pinned;
    row.want = want;
    script.push_back(row);
  endtask

  function automatic request_t draw_request();
    request_t r;
    int start;
    int idx;
    int unsigned dice;
    r = '0;
    case ($urandom_range(19))
      0: wall = wall - $urandom_range(100);
      1: wall = wall + $urandom_range(200000);
      default: wall = wall + $urandom_range(3 + idle_limit / 4);
    endcase
    r.now = wall;
    r.tls = 1'($urandom_range(1));
    r.alive = $urandom_range(99) < 85;
    r.ok = $urandom_range(99) < 90;
    case ($urandom_range(3))
      0: r.host = '0;
      1: r.host = '1;
      2: r.host = 32'h5A5A_0F0F;
      default: r.host = 32'h0000_1000;
    endcase
    case ($urandom_range(2))
      0: r.port = '0;
      1: r.port = 16'd443;
      default: r.port = '1;
    endcase
    r.handle = HANDLE_W'($urandom_range(15));
    dice = $urandom_range(99);
    if (dice < 8) begin
      r.command = CMD_W'($urandom_range(3));
      r.host = $urandom;
      r.port = PORT_W'($urandom);
      r.now = $urandom;
    end else if (dice < 52) begin
      r.command = CMD_ACQUIRE;
    end else if (dice < 97) begin
      r.command = (dice < 85) ? CMD_RELEASE : CMD_EVICT;
      if ($urandom_range(99) < 80) begin
        start = $urandom_range(POOL_SLOTS - 1);
        for (int k = 0; k < POOL_SLOTS; k++) begin
          idx = (start + k) % POOL_SLOTS;
          if (pool_valid[idx] && (pool_busy[idx] || r.command == CMD_EVICT)) begin
            r.handle = HANDLE_W'(idx);
            break;
          end
        end
      end
    end else begin
      r.command = CMD_UNUSED;
    end
    return r;
  endfunction

  task automatic offer(request_t r, bit pinned, outcome_t want);
    outcome_t got;
    req_bus.valid      <= 1'b1;
    req_bus.command    <= r.command;
    req_bus.host_key   <= r.host;
    req_bus.port       <= r.port;
    req_bus.is_tls     <= r.tls;
    req_bus.alive      <= r.alive;
    req_bus.connect_ok <= r.ok;
    req_bus.now_time   <= r.now;
    req_bus.handle     <= r.handle;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    got = pool_outcome(r);
    pending_outcomes.push_back(pinned ? want : got);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic set_timeout(logic [TMO_W-1:0] value);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    idle_limit = value;
  endtask

  function automatic void check_field(string what, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual status %0d slot %0d",
                 $time, rsp_bus.status, rsp_bus.slot);
        mismatches++;
      end else begin
        want = pending_outcomes.pop_front();
        check_field("status", {1'b0, want.status}, {1'b0, rsp_bus.status});
        check_field("slot", want.slot, rsp_bus.slot);
        check_field("evicted_count", want.evicted, rsp_bus.evicted_count);
      end
    end
  end

  initial begin
    int hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= $urandom_range(99) >= rx_stall_pct;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** connection_slot_pool_policy_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    int unsigned tmo_plan [PHASES];
    int unsigned tx_plan [PHASES];
    int unsigned rx_plan [PHASES];
    tmo_plan = '{60, 0, 65535, 0, 5, 0};
    tx_plan  = '{0, 84, 0, 22, 0, 22};
    rx_plan  = '{0, 0, 84, 22, 0, 22};
    tmo_plan[3] = $urandom_range(400, 1);
    tmo_plan[5] = $urandom_range(65535);

    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    req_bus.valid      <= 1'b0;
    req_bus.command    <= '0;
    req_bus.host_key   <= '0;
    req_bus.port       <= '0;
    req_bus.is_tls     <= 1'b0;
    req_bus.alive      <= 1'b0;
    req_bus.connect_ok <= 1'b0;
    req_bus.now_time   <= '0;
    req_bus.handle     <= '0;
    idle_limit = TIMEOUT_RESET;
    foreach (pool_valid[i]) begin
      pool_valid[i] = 1'b0;
      pool_busy[i] = 1'b0;
    end

    // The pool starts empty, so release and evict have nothing to act on.
    add_row(slot_req(CMD_RELEASE, 4'd0, 32'd0), 1'b1, outc(ST_BYPASS_CLOSED, NO_SLOT, 4'd0));
    add_row(slot_req(CMD_EVICT, 4'd8, 32'd0), 1'b1, outc(ST_BYPASS_CLOSED, NO_SLOT, 4'd0));
    add_row(slot_req(CMD_UNUSED, 4'd0, 32'd0), 1'b1, outc(ST_BYPASS_CLOSED, NO_SLOT, 4'd0));
    add_row(slot_req(CMD_RELEASE, 4'd15, '1), 1'b1, outc(ST_BYPASS_CLOSED, NO_SLOT, 4'd0));
    add_row(acq_req('1, '1, 1'b1, 1'b1, 1'b1, 32'd100), 1'b1, outc(ST_NEW_POOLED, 4'd0, 4'd0));
    add_row(acq_req('0, '0, 1'b0, 1'b0, 1'b0, 32'd0), 1'b1, outc(ST_CONNECT_FAIL, NO_SLOT, 4'd0));
    add_row(slot_req(CMD_RELEASE, 4'd0, 32'd200), 1'b1, outc(ST_SLOT_UPDATED, 4'd0, 4'd0));
    // Idle for exactly the timeout is still fresh; one time unit more is expired.
    add_row(acq_req('1, '1, 1'b1, 1'b1, 1'b1, 32'd260), 1'b1, outc(ST_REUSED, 4'd0, 4'd0));
    add_row(slot_req(CMD_RELEASE, 4'd0, 32'd300), 1'b1, outc(ST_SLOT_UPDATED, 4'd0, 4'd0));
    add_row(acq_req('1, '1, 1'b1, 1'b1, 1'b1, 32'd361), 1'b1, outc(ST_NEW_POOLED, 4'd0, 4'd1));
    // A stamp in the future never counts as expired.
    add_row(slot_req(CMD_RELEASE, 4'd0, 32'd1000), 1'b1, outc(ST_SLOT_UPDATED, 4'd0, 4'd0));
    add_row(acq_req('1, '1, 1'b1, 1'b1, 1'b1, 32'd500), 1'b1, outc(ST_REUSED, 4'd0, 4'd0));
    add_row(slot_req(CMD_RELEASE, 4'd0, 32'd600), 1'b1, outc(ST_SLOT_UPDATED, 4'd0, 4'd0));
    add_row(acq_req('1, '1, 1'b1, 1'b0, 1'b1, 32'd601), 1'b1, outc(ST_NEW_POOLED, 4'd0, 4'd1));
    add_row(acq_req('1, '1, 1'b1, 1'b1, 1'b1, 32'd601), 1'b0, '0);
    for (int h = 1; h <= 6; h++) begin
      add_row(acq_req(HOST_W'(h), 16'd80, 1'b0, 1'b1, 1'b1, 32'd1000), 1'b0, '0);
    end
    add_row(acq_req(32'd7, 16'd80, 1'b0, 1'b1, 1'b1, 32'd1001), 1'b1,
            outc(ST_NEW_BYPASS, NO_SLOT, 4'd0));
    add_row(slot_req(CMD_RELEASE, 4'd2, 32'd5000), 1'b0, '0);
    add_row(slot_req(CMD_RELEASE, 4'd3, 32'd5000), 1'b0, '0);
    // Only stamps strictly older than now may be taken as the oldest slot.
    add_row(acq_req(32'd7, 16'd80, 1'b0, 1'b1, 1'b1, 32'd5000), 1'b1,
            outc(ST_NEW_BYPASS, NO_SLOT, 4'd0));
    add_row(acq_req(32'd7, 16'd80, 1'b0, 1'b1, 1'b1, '1), 1'b0, '0);
    add_row(slot_req(CMD_EVICT, 4'd3, 32'd0), 1'b1, outc(ST_SLOT_UPDATED, 4'd3, 4'd1));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[k]) offer(script[k].req, script[k].pinned, script[k].want);

    wall = 32'd7000;
    for (int p = 0; p < PHASES; p++) begin
      set_timeout(TMO_W'(tmo_plan[p]));
      tx_idle_pct = tx_plan[p];
      rx_stall_pct = rx_plan[p];
      if (p == 4) wall = 32'hFFFF_F000;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 0 && n == 100) hold_asks <= hold_asks + 1;
        offer(draw_request(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("** connection_slot_pool_policy_unit: PASSED **");
    end else begin
      $display("** connection_slot_pool_policy_unit: FAILED **");
    end
    $finish;
  end

endmodule
